[design/bwp_pkg.sv]
// bwp_pkg: types, request codes and helpers for the bitstream word packer
// no dependencies; imported by every module of the block
package bwp_pkg;

    localparam int COUNT_BITS = 30;

    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_PAD     = 2'd1,
        REQ_FINISH  = 2'd2,
        REQ_RESTART = 2'd3
    } req_type_t;

    typedef struct packed {
        req_type_t   req_type;
        logic [31:0] field_value;
        logic [5:0]  field_width;
    } in_item_t;

    typedef struct packed {
        logic [31:0] packed_word;
        logic        is_final;
        logic        has_word;
        logic [31:0] total_bytes;
    } out_item_t;

    typedef struct packed {
        logic [4:0]            fill;
        logic [31:0]           acc;
        logic [COUNT_BITS-1:0] words;
    } pack_state_t;

    // four bytes per word, wrapped to 32 bits
    function automatic logic [31:0] bytes_of(logic [COUNT_BITS-1:0] words);
        logic [63:0] t;
        t = 64'({words, 2'b00});
        return t[31:0];
    endfunction

endpackage

[design/bwp_step.sv]
// bwp_step: combinational next-state and result logic for one word request
// depends on bwp_pkg
module bwp_step (
    input  bwp_pkg::pack_state_t cur,
    input  bwp_pkg::in_item_t    item,
    output bwp_pkg::pack_state_t nxt,
    output logic                 res_valid,
    output bwp_pkg::out_item_t   res
);
    import bwp_pkg::*;

    logic [31:0]           app_v;
    logic [5:0]            app_w;
    logic [3:0]            gap;
    logic [31:0]           mask;
    logic [31:0]           v_m;
    logic [5:0]            total;
    logic [4:0]            over;
    logic [COUNT_BITS-1:0] words_inc;

    always_comb
    begin
        app_v     = '0;
        app_w     = '0;
        nxt       = cur;
        res_valid = 1'b0;
        res       = '0;
        gap       = 4'd8 - {1'b0, cur.fill[2:0]};
        words_inc = cur.words + COUNT_BITS'(1);

        case (item.req_type)
            REQ_WRITE:
            begin
                app_w = (item.field_width > 6'd32) ? 6'd32 : item.field_width;
                app_v = item.field_value;
            end
            REQ_PAD:
            begin
                // one 0 bit then ones up to the byte boundary
                if (cur.fill[2:0] != 3'd0)
                begin
                    app_w = {2'b00, gap};
                    app_v = (32'd1 << (gap - 4'd1)) - 32'd1;
                end
            end
            REQ_FINISH:
            begin
                res_valid    = 1'b1;
                res.is_final = 1'b1;
                if (cur.fill != 5'd0)
                begin
                    res.packed_word = cur.acc;
                    res.has_word    = 1'b1;
                    res.total_bytes = bytes_of(words_inc);
                end
                else
                begin
                    res.total_bytes = bytes_of(cur.words);
                end
            end
            REQ_RESTART:
            begin
                nxt = '0;
            end
            default:
            begin
            end
        endcase

        mask  = app_w[5] ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF << app_w[4:0]);
        v_m   = app_v & mask;
        total = {1'b0, cur.fill} + app_w;
        // above 31, total minus one word is just the low five bits
        over  = total[4:0];

        if (app_w != 6'd0)
        begin
            if (total < 6'd32)
            begin
                nxt.acc  = cur.acc | (v_m << (6'd32 - total));
                nxt.fill = total[4:0];
            end
            else
            begin
                nxt.words       = words_inc;
                nxt.acc         = (over == 5'd0) ? 32'd0 : (v_m << (6'd32 - {1'b0, over}));
                nxt.fill        = over;
                res_valid       = 1'b1;
                res.packed_word = cur.acc | (v_m >> over);
                res.has_word    = 1'b1;
                res.total_bytes = bytes_of(words_inc);
            end
        end
    end

endmodule

[design/bitstream_word_packer_top.sv]
// bitstream_word_packer_top: input register, packing state and result register
// depends on bwp_pkg and bwp_step
//
// Packs fields of 0 to 32 bits, most significant bit first, into 32-bit words
// and hands each word out as it fills. Requests are write field, pad to a byte
// boundary, finish (partial word zero-filled plus byte count, state kept) and
// restart. One request is taken every clock cycle while req_stall is low. An
// accepted request loads the input register, and the packing step (a shift,
// an OR and a compare against the fill count) then loads the result register,
// which offers the result on res. The result register stalling backs up into
// req_stall once the input register is occupied.
module bitstream_word_packer_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  bwp_pkg::in_item_t  req,
    output logic               res_valid,
    input  logic               res_stall,
    output bwp_pkg::out_item_t res
);
    import bwp_pkg::*;

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    pack_state_t state_reg;
    pack_state_t state_next;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    logic        step_valid;
    out_item_t   step_res;
    logic        advance;
    logic        process;

    bwp_step u_step (
        .cur       (state_reg),
        .item      (in_item_reg),
        .nxt       (state_next),
        .res_valid (step_valid),
        .res       (step_res)
    );

    assign advance   = !out_valid_reg || !res_stall;
    assign process   = in_valid_reg && advance;
    assign req_stall = in_valid_reg && !advance;
    assign res_valid = out_valid_reg;
    assign res       = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
                in_valid_reg <= 1'b1;
            else if (process)
                in_valid_reg <= 1'b0;

            if (process)
                state_reg <= state_next;

            if (advance)
                out_valid_reg <= process && step_valid;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            in_item_reg <= req;
        if (process && step_valid)
            out_item_reg <= step_res;
    end

endmodule

[design/bwp_checker.sv]
// bwp_checker: port-level assertions for the bitstream word packer, with bind
// depends on bwp_pkg and bitstream_word_packer_top
module bwp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input bwp_pkg::in_item_t  req,
    input logic               res_valid,
    input logic               res_stall,
    input bwp_pkg::out_item_t res
);
    import bwp_pkg::*;

    // a filled word always carries bits
    a_word_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.is_final |-> res.has_word)
        else $error("filled word without has_word");

    // byte counts are whole words
    a_bytes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.total_bytes[1:0] == 2'b00)
        else $error("total_bytes not a multiple of four");

    // finish with empty buffer reports a zero word
    a_empty_finish: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.is_final && !res.has_word |-> res.packed_word == 32'd0)
        else $error("empty finish with nonzero word");

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed");

endmodule

bind bitstream_word_packer_top bwp_checker u_bwp_checker (.*);

[bench/tb.sv]
// tb: self-checking bench for bitstream_word_packer_top
// depends on bwp_pkg and the design sources; a clocked driver and monitor around u_dut
// predicts every word and finish report from a local copy of the packing state
module tb;
    import bwp_pkg::*;

    localparam int IDLE_PCT   = 15;
    localparam int CYCLE_MAX  = 200000;
    localparam int DRAIN_WAIT = 8;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    in_item_t   req       = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    out_item_t  res;

    bitstream_word_packer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // local copy of the packing state
    logic [4:0]            pk_fill  = '0;
    logic [31:0]           pk_acc   = '0;
    logic [COUNT_BITS-1:0] pk_words = '0;

    in_item_t  pending_reqs[$];
    out_item_t expected_words[$];
    int        n_acc      = 0;
    int        n_err      = 0;
    int        cycle_cnt  = 0;
    int        hold_left  = 0;
    bit        hold_done  = 1'b0;

    function automatic logic [31:0] bytes_for(logic [COUNT_BITS-1:0] words);
        return 32'(words) << 2;
    endfunction

    // append up to 32 bits msb first; returns 1 when a word completes
    function automatic bit append_field(input logic [31:0] v, input logic [5:0] w,
                                        output out_item_t r);
        logic [5:0]  n;
        logic [5:0]  total;
        logic [5:0]  over;
        logic [31:0] word;
        n = (w > 6'd32) ? 6'd32 : w;
        r = '0;
        if (n == 6'd0)
            return 1'b0;
        if (n < 6'd32)
            v = v & ((32'd1 << n) - 32'd1);
        total = {1'b0, pk_fill} + n;
        if (total < 6'd32)
        begin
            pk_acc  = pk_acc | (v << (6'd32 - total));
            pk_fill = total[4:0];
            return 1'b0;
        end
        over     = total - 6'd32;
        word     = pk_acc | (v >> over);
        pk_words = pk_words + 1'b1;
        pk_acc   = (over == 6'd0) ? 32'd0 : (v << (6'd32 - over));
        pk_fill  = over[4:0];
        r.packed_word = word;
        r.is_final    = 1'b0;
        r.has_word    = 1'b1;
        r.total_bytes = bytes_for(pk_words);
        return 1'b1;
    endfunction

    function automatic bit pack_request(input in_item_t it, output out_item_t r);
        logic [3:0]            gap;
        logic [COUNT_BITS-1:0] nw;
        bit                    got;
        r   = '0;
        got = 1'b0;
        case (it.req_type)
            REQ_WRITE:
                got = append_field(it.field_value, it.field_width, r);
            REQ_PAD:
            begin
                gap = 4'd8 - {1'b0, pk_fill[2:0]};
                if (gap == 4'd1)
                    got = append_field(32'd0, 6'd1, r);
                else if (gap != 4'd8)
                    got = append_field((32'd1 << (gap - 4'd1)) - 32'd1, {2'b00, gap}, r);
            end
            REQ_FINISH:
            begin
                got        = 1'b1;
                r.is_final = 1'b1;
                if (pk_fill != 5'd0)
                begin
                    nw            = pk_words + 1'b1;
                    r.packed_word = pk_acc;
                    r.has_word    = 1'b1;
                    r.total_bytes = bytes_for(nw);
                end
                else
                begin
                    r.packed_word = 32'd0;
                    r.has_word    = 1'b0;
                    r.total_bytes = bytes_for(pk_words);
                end
            end
            default:
            begin
                pk_fill  = '0;
                pk_acc   = '0;
                pk_words = '0;
            end
        endcase
        return got;
    endfunction

    function automatic in_item_t mk(req_type_t t, logic [31:0] v, logic [5:0] w);
        in_item_t it;
        it.req_type    = t;
        it.field_value = v;
        it.field_width = w;
        return it;
    endfunction

    // mostly writes so words fill and the byte count climbs; restarts kept rare
    function automatic in_item_t random_request();
        int        k;
        int        wk;
        req_type_t t;
        logic [31:0] v;
        logic [5:0]  w;
        k  = $urandom_range(99);
        wk = $urandom_range(99);
        if (k < 62)
            t = REQ_WRITE;
        else if (k < 80)
            t = REQ_PAD;
        else if (k < 96)
            t = REQ_FINISH;
        else
            t = REQ_RESTART;
        if (wk < 40)
            w = 6'($urandom_range(8, 1));
        else if (wk < 88)
            w = 6'($urandom_range(32, 0));
        else
            w = 6'($urandom_range(63, 33));
        v = ($urandom_range(9) == 0) ? 32'hffff_ffff : 32'($urandom);
        return mk(t, v, w);
    endfunction

    function automatic bit no_idle_window();
        return (n_acc >= 250 && n_acc < 330);
    endfunction

    // driver: payload held while stalled
    always @(posedge clk)
    begin
        out_item_t r;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                n_acc = n_acc + 1;
                if (pack_request(req, r))
                    expected_words.push_back(r);
            end
            if (!req_valid || !req_stall)
            begin
                if (pending_reqs.size() != 0 &&
                    (no_idle_window() || $urandom_range(99) >= IDLE_PCT))
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall, with one long hold-off to back the block up
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected word: packed_word %h total_bytes %h",
                           res.packed_word, res.total_bytes);
                    n_err = n_err + 1;
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (res.packed_word !== e.packed_word)
                    begin
                        $error("packed_word: expected %h, got %h", e.packed_word,
                               res.packed_word);
                        n_err = n_err + 1;
                    end
                    if (res.is_final !== e.is_final)
                    begin
                        $error("is_final: expected %b, got %b", e.is_final, res.is_final);
                        n_err = n_err + 1;
                    end
                    if (res.has_word !== e.has_word)
                    begin
                        $error("has_word: expected %b, got %b", e.has_word, res.has_word);
                        n_err = n_err + 1;
                    end
                    if (res.total_bytes !== e.total_bytes)
                    begin
                        $error("total_bytes: expected %h, got %h", e.total_bytes,
                               res.total_bytes);
                        n_err = n_err + 1;
                    end
                end
            end
            if (!hold_done && n_acc >= 120)
            begin
                hold_done = 1'b1;
                hold_left = 60;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                res_stall <= 1'b1;
            end
            else if (no_idle_window())
                res_stall <= 1'b0;
            else
                res_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin
        while (cycle_cnt < CYCLE_MAX)
        begin
            @(posedge clk);
            cycle_cnt = cycle_cnt + 1;
        end
        $display("tb: done, errors");
        $finish;
    end

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_valid || expected_words.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        // directed: extremes, every request, each corner of pad and finish
        pending_reqs.push_back(mk(REQ_RESTART, 32'hffff_ffff, 6'd63));
        pending_reqs.push_back(mk(REQ_FINISH,  32'h0000_0000, 6'd0));   // empty buffer
        pending_reqs.push_back(mk(REQ_WRITE,   32'hffff_ffff, 6'd0));   // zero width
        pending_reqs.push_back(mk(REQ_WRITE,   32'hffff_ffff, 6'd32));
        pending_reqs.push_back(mk(REQ_WRITE,   32'h0000_0000, 6'd32));
        pending_reqs.push_back(mk(REQ_WRITE,   32'hffff_ffff, 6'd1));
        pending_reqs.push_back(mk(REQ_PAD,     32'h0000_0000, 6'd0));   // zero then ones
        pending_reqs.push_back(mk(REQ_PAD,     32'hffff_ffff, 6'd63));  // already aligned
        pending_reqs.push_back(mk(REQ_WRITE,   32'h0000_0055, 6'd7));
        pending_reqs.push_back(mk(REQ_PAD,     32'h0000_0000, 6'd0));   // one bit to go
        pending_reqs.push_back(mk(REQ_FINISH,  32'hffff_ffff, 6'd63));  // partial word
        pending_reqs.push_back(mk(REQ_WRITE,   32'ha5a5_a5a5, 6'd63));  // saturated width
        pending_reqs.push_back(mk(REQ_WRITE,   32'h1234_5678, 6'd33));
        pending_reqs.push_back(mk(REQ_WRITE,   32'hffff_8001, 6'd15));
        pending_reqs.push_back(mk(REQ_PAD,     32'h0000_0000, 6'd0));   // single bit fills word
        pending_reqs.push_back(mk(REQ_WRITE,   32'h0000_000f, 6'd4));
        pending_reqs.push_back(mk(REQ_WRITE,   32'h02aa_aaaa, 6'd26));
        pending_reqs.push_back(mk(REQ_PAD,     32'h0000_0000, 6'd0));   // pad fills word
        pending_reqs.push_back(mk(REQ_FINISH,  32'h0000_0000, 6'd0));
        pending_reqs.push_back(mk(REQ_WRITE,   32'h7fff_ffff, 6'd31));
        pending_reqs.push_back(mk(REQ_WRITE,   32'h8000_0001, 6'd32));
        pending_reqs.push_back(mk(REQ_FINISH,  32'h0000_0000, 6'd0));
        pending_reqs.push_back(mk(REQ_RESTART, 32'h0000_0000, 6'd0));
        pending_reqs.push_back(mk(REQ_FINISH,  32'h0000_0000, 6'd0));
        pending_reqs.push_back(mk(REQ_WRITE,   32'($urandom), 6'd17));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // sender pauses here until every word is back
        wait_drained();
        for (int i = 0; i < 200; i++)
            pending_reqs.push_back(random_request());
        wait_drained();
        for (int i = 0; i < 200; i++)
            pending_reqs.push_back(random_request());
        wait_drained();
        repeat (DRAIN_WAIT) @(negedge clk);

        if (n_err == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
